// ===== rtl/core/bbld_pkg.sv =====
// ----------------------------------------------------------------------------
// bbld_pkg
// Shared types, codes and helpers of the byte-budgeted lru directory.
// ----------------------------------------------------------------------------
package bbld_pkg;

    localparam int DEPTH_DEF    = 16;
    localparam int KEY_BITS_DEF = 32;
    localparam int USED_W       = 40;

    // request kinds
    localparam logic [1:0] ACT_GET   = 2'd0;
    localparam logic [1:0] ACT_PUT   = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    // configuration register indexes
    localparam logic CFG_BYTE_LIMIT = 1'b0;
    localparam logic CFG_CHECKS_ON  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_MISS      = 2'd1,
        ST_TOO_LARGE = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        C_NONE,
        C_LOAD,
        C_CLEAR,
        C_FIND_INIT,
        C_FIND_STEP,
        C_VIC_INIT,
        C_VIC_STEP,
        C_EV_READ,
        C_EV_MOVE,
        C_COMMIT_U,
        C_INSERT,
        C_EMIT_GET,
        C_EMIT_FINAL
    } t_cmd;

    typedef struct packed {
        t_cmd    op;
        t_status st;
    } t_ctrl_cmd;

    typedef struct packed {
        logic [1:0] action;
        logic       limit_zero;
        logic       checks;
        logic       too_big;
        logic       at_end;
        logic       match;
        logic       vic_done;
        logic       fits_u;
        logic       fits_i;
        logic       live_zero;
        logic       table_full;
        logic       vic_is_idx;
        logic       out_free;
    } t_dp_stat;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_FIND,
        S_GET_OUT,
        S_U_CHECK,
        S_I_CHECK,
        S_VIC,
        S_VCHK,
        S_EV_MOVE,
        S_COMMIT,
        S_INSERT,
        S_FINAL
    } t_state;

    function automatic logic [USED_W-1:0] sat_add(input logic [USED_W-1:0] a,
                                                  input logic [31:0] b);
        logic [USED_W:0] s;
        s = {1'b0, a} + (USED_W + 1)'(b);
        return s[USED_W] ? {USED_W{1'b1}} : s[USED_W-1:0];
    endfunction

    function automatic logic [USED_W-1:0] sub_floor(input logic [USED_W-1:0] a,
                                                    input logic [31:0] b);
        return (a >= USED_W'(b)) ? a - USED_W'(b) : '0;
    endfunction

endpackage

// ===== rtl/core/bbld_dp.sv =====
// ----------------------------------------------------------------------------
// bbld_dp
// Directory datapath: entry stores, byte and write counters, scan pointer,
// victim search registers and the result register.
// ----------------------------------------------------------------------------
module bbld_dp
    import bbld_pkg::*;
#(
    parameter int DEPTH    = DEPTH_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_ctrl_cmd   i_cmd,
    input  logic [1:0]  i_in_action,
    input  logic [31:0] i_in_key,
    input  logic [31:0] i_in_bytes,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output t_dp_stat    o_stat,
    input  logic        i_out_ready,
    output logic        o_out_valid,
    output logic        o_out_ev,
    output logic [31:0] o_out_key,
    output logic [1:0]  o_out_status,
    output logic [31:0] o_out_bytes,
    output logic [39:0] o_out_used,
    output logic        o_out_last
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [KEY_BITS-1:0] r_key_mem   [DEPTH];
    logic [31:0]         r_size_mem  [DEPTH];
    logic [63:0]         r_stamp_mem [DEPTH];

    logic [CW-1:0]       r_live;
    logic [USED_W-1:0]   r_used;
    logic [63:0]         r_wclk;
    logic [31:0]         r_limit;
    logic                r_checks;
    logic [1:0]          r_act;
    logic [KEY_BITS-1:0] r_key;
    logic [31:0]         r_size;
    logic [CW-1:0]       r_ptr;
    logic [IW-1:0]       r_idx;
    logic [31:0]         r_idx_size;
    logic                r_found;
    logic [IW-1:0]       r_best;
    logic [63:0]         r_best_stamp;
    logic [IW-1:0]       r_victim;
    logic [KEY_BITS-1:0] r_ev_key;
    logic [31:0]         r_ev_size;
    logic                r_ov;
    logic                r_oev;
    logic [31:0]         r_okey;
    logic [1:0]          r_ost;
    logic [31:0]         r_obytes;
    logic [39:0]         r_oused;
    logic                r_olast;

    logic [63:0]         w_in64;
    logic [KEY_BITS-1:0] w_in_key;
    logic [63:0]         w_ev64;
    logic [CW-1:0]       w_live_m1;
    logic [IW-1:0]       w_last_ix;
    logic [IW-1:0]       w_raddr;
    logic [KEY_BITS-1:0] w_rd_key;
    logic [31:0]         w_rd_size;
    logic [63:0]         w_rd_stamp;
    logic [USED_W-1:0]   w_rest;
    logic                w_at_end;
    logic                w_emit;
    logic                w_hit;

    assign w_in64    = {32'b0, i_in_key};
    assign w_in_key  = w_in64[KEY_BITS-1:0];
    assign w_ev64    = 64'(r_ev_key);
    assign w_live_m1 = r_live - 1'b1;
    assign w_last_ix = w_live_m1[IW-1:0];

    always_comb begin
        unique case (i_cmd.op)
            C_EV_READ: w_raddr = r_victim;
            C_EV_MOVE: w_raddr = w_last_ix;
            default:   w_raddr = r_ptr[IW-1:0];
        endcase
    end

    assign w_rd_key   = r_key_mem[w_raddr];
    assign w_rd_size  = r_size_mem[w_raddr];
    assign w_rd_stamp = r_stamp_mem[w_raddr];

    assign w_at_end = (r_ptr == r_live);
    assign w_rest   = sub_floor(r_used, r_idx_size);
    assign w_emit   = (i_cmd.op == C_EV_MOVE) || (i_cmd.op == C_EMIT_GET)
                   || (i_cmd.op == C_EMIT_FINAL);
    assign w_hit    = r_found && (r_idx_size != 32'd0);

    always_comb begin
        o_stat.action     = r_act;
        o_stat.limit_zero = (r_limit == 32'd0);
        o_stat.checks     = r_checks;
        o_stat.too_big    = (r_size > r_limit);
        o_stat.at_end     = w_at_end;
        o_stat.match      = !w_at_end && (w_rd_key == r_key);
        o_stat.vic_done   = w_at_end || (w_rd_size == 32'd0);
        o_stat.fits_u     = ((USED_W + 1)'(w_rest) + (USED_W + 1)'(r_size))
                            <= (USED_W + 1)'(r_limit);
        o_stat.fits_i     = ((USED_W + 1)'(r_used) + (USED_W + 1)'(r_size))
                            <= (USED_W + 1)'(r_limit);
        o_stat.live_zero  = (r_live == '0);
        o_stat.table_full = (r_live >= CW'(DEPTH));
        o_stat.vic_is_idx = (r_victim == r_idx);
        o_stat.out_free   = !r_ov || i_out_ready;
    end

    // control state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live   <= '0;
            r_used   <= '0;
            r_wclk   <= '0;
            r_limit  <= '0;
            r_checks <= 1'b1;
            r_ov     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_BYTE_LIMIT: r_limit  <= i_cfg_data;
                    CFG_CHECKS_ON:  r_checks <= i_cfg_data[0];
                endcase
            end
            unique case (i_cmd.op)
                C_CLEAR: begin
                    r_live <= '0;
                    r_used <= '0;
                    r_wclk <= '0;
                end
                C_EV_MOVE: begin
                    r_live <= w_live_m1;
                    r_used <= sub_floor(r_used, r_ev_size);
                end
                C_COMMIT_U: begin
                    r_used <= sat_add(w_rest, r_size);
                    r_wclk <= r_wclk + 64'd1;
                end
                C_INSERT: begin
                    r_live <= r_live + 1'b1;
                    r_used <= sat_add(r_used, r_size);
                    r_wclk <= r_wclk + 64'd1;
                end
                default: ;
            endcase
            if (w_emit)
                r_ov <= 1'b1;
            else if (i_out_ready)
                r_ov <= 1'b0;
        end
    end

    // request fields, scan registers and result payload
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            C_LOAD: begin
                r_act  <= i_in_action;
                r_key  <= w_in_key;
                r_size <= i_in_bytes;
            end
            C_FIND_INIT: begin
                r_ptr   <= '0;
                r_found <= 1'b0;
            end
            C_FIND_STEP: begin
                if (o_stat.match) begin
                    r_found    <= 1'b1;
                    r_idx      <= r_ptr[IW-1:0];
                    r_idx_size <= w_rd_size;
                end else if (!w_at_end) begin
                    r_ptr <= r_ptr + 1'b1;
                end
            end
            C_VIC_INIT: begin
                r_ptr        <= '0;
                r_best       <= '0;
                r_best_stamp <= '1;
            end
            C_VIC_STEP: begin
                if (w_at_end) begin
                    r_victim <= r_best;
                end else if (w_rd_size == 32'd0) begin
                    r_victim <= r_ptr[IW-1:0];
                end else begin
                    if (w_rd_stamp < r_best_stamp) begin
                        r_best_stamp <= w_rd_stamp;
                        r_best       <= r_ptr[IW-1:0];
                    end
                    r_ptr <= r_ptr + 1'b1;
                end
            end
            C_EV_READ: begin
                r_ev_key  <= w_rd_key;
                r_ev_size <= w_rd_size;
            end
            C_EV_MOVE: begin
                // the entry being updated may be the one moved into the hole
                if (r_idx == w_last_ix)
                    r_idx <= r_victim;
                r_oev    <= 1'b1;
                r_okey   <= w_ev64[31:0];
                r_ost    <= ST_OK;
                r_obytes <= r_ev_size;
                r_oused  <= sub_floor(r_used, r_ev_size);
                r_olast  <= 1'b0;
            end
            C_EMIT_GET: begin
                r_oev    <= 1'b0;
                r_okey   <= '0;
                r_ost    <= w_hit ? ST_OK : ST_MISS;
                r_obytes <= w_hit ? r_idx_size : 32'd0;
                r_oused  <= r_used;
                r_olast  <= 1'b1;
            end
            C_EMIT_FINAL: begin
                r_oev    <= 1'b0;
                r_okey   <= '0;
                r_ost    <= i_cmd.st;
                r_obytes <= '0;
                r_oused  <= r_used;
                r_olast  <= 1'b1;
            end
            default: ;
        endcase
    end

    // entry stores
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            C_EV_MOVE: begin
                // last live entry fills the freed slot
                if (CW'(r_victim) < w_live_m1) begin
                    r_key_mem[r_victim]   <= w_rd_key;
                    r_size_mem[r_victim]  <= w_rd_size;
                    r_stamp_mem[r_victim] <= w_rd_stamp;
                end
            end
            C_COMMIT_U: begin
                r_size_mem[r_idx]  <= r_size;
                r_stamp_mem[r_idx] <= r_wclk + 64'd1;
            end
            C_INSERT: begin
                r_key_mem[r_live[IW-1:0]]   <= r_key;
                r_size_mem[r_live[IW-1:0]]  <= r_size;
                r_stamp_mem[r_live[IW-1:0]] <= r_wclk + 64'd1;
            end
            default: ;
        endcase
    end

    assign o_out_valid  = r_ov;
    assign o_out_ev     = r_oev;
    assign o_out_key    = r_okey;
    assign o_out_status = r_ost;
    assign o_out_bytes  = r_obytes;
    assign o_out_used   = r_oused;
    assign o_out_last   = r_olast;

    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= CW'(DEPTH))
        else $error("live count above depth");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |-> (!r_ov || i_out_ready))
        else $error("result written over a pending one");

    a_evict_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == C_EV_MOVE) |-> (r_live != '0 && CW'(r_victim) < r_live))
        else $error("eviction outside live entries");

    a_insert_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == C_INSERT) |-> (r_live < CW'(DEPTH)))
        else $error("insert into a full table");

endmodule

// ===== rtl/core/bbld_ctrl.sv =====
// ----------------------------------------------------------------------------
// bbld_ctrl
// Request sequencer: key search, victim search, eviction loop and results.
// ----------------------------------------------------------------------------
module bbld_ctrl
    import bbld_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_dp_stat  i_stat,
    output t_ctrl_cmd o_cmd
);

    t_state  r_state, n_state;
    logic    r_upd, n_upd;
    t_status r_st, n_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_upd   <= 1'b0;
            r_st    <= ST_OK;
        end else begin
            r_state <= n_state;
            r_upd   <= n_upd;
            r_st    <= n_st;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_upd      = r_upd;
        n_st       = r_st;
        o_cmd.op   = C_NONE;
        o_cmd.st   = r_st;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = C_LOAD;
                    n_state  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_state = S_FINAL;
                n_st    = ST_OK;
                priority if (i_stat.action == ACT_GET) begin
                    if (i_stat.limit_zero) begin
                        n_st = ST_MISS;
                    end else begin
                        o_cmd.op = C_FIND_INIT;
                        n_state  = S_FIND;
                    end
                end else if (i_stat.action == ACT_PUT) begin
                    if (i_stat.limit_zero) begin
                        n_st = ST_OK;
                    end else if (i_stat.checks && i_stat.too_big) begin
                        n_st = ST_TOO_LARGE;
                    end else begin
                        o_cmd.op = C_FIND_INIT;
                        n_state  = S_FIND;
                    end
                end else if (i_stat.action == ACT_CLEAR) begin
                    o_cmd.op = C_CLEAR;
                end else begin
                    n_st = ST_OK;
                end
            end
            S_FIND: begin
                o_cmd.op = C_FIND_STEP;
                if (i_stat.match || i_stat.at_end) begin
                    n_upd = i_stat.match;
                    if (i_stat.action == ACT_GET)
                        n_state = S_GET_OUT;
                    else if (i_stat.match)
                        n_state = S_U_CHECK;
                    else
                        n_state = S_I_CHECK;
                end
            end
            S_GET_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.op = C_EMIT_GET;
                    n_state  = S_IDLE;
                end
            end
            S_U_CHECK: begin
                if (!i_stat.checks || i_stat.fits_u) begin
                    n_state = S_COMMIT;
                end else begin
                    o_cmd.op = C_VIC_INIT;
                    n_state  = S_VIC;
                end
            end
            S_I_CHECK: begin
                priority if (i_stat.checks && !i_stat.fits_i) begin
                    if (i_stat.live_zero) begin
                        n_st    = ST_TOO_LARGE;
                        n_state = S_FINAL;
                    end else begin
                        o_cmd.op = C_VIC_INIT;
                        n_state  = S_VIC;
                    end
                end else if (i_stat.table_full) begin
                    n_st    = ST_FULL;
                    n_state = S_FINAL;
                end else begin
                    n_state = S_INSERT;
                end
            end
            S_VIC: begin
                o_cmd.op = C_VIC_STEP;
                if (i_stat.vic_done)
                    n_state = S_VCHK;
            end
            S_VCHK: begin
                // an update never evicts its own entry
                if (r_upd && i_stat.vic_is_idx) begin
                    n_st    = ST_TOO_LARGE;
                    n_state = S_FINAL;
                end else begin
                    o_cmd.op = C_EV_READ;
                    n_state  = S_EV_MOVE;
                end
            end
            S_EV_MOVE: begin
                if (i_stat.out_free) begin
                    o_cmd.op = C_EV_MOVE;
                    n_state  = r_upd ? S_U_CHECK : S_I_CHECK;
                end
            end
            S_COMMIT: begin
                o_cmd.op = C_COMMIT_U;
                n_st     = ST_OK;
                n_state  = S_FINAL;
            end
            S_INSERT: begin
                o_cmd.op = C_INSERT;
                n_st     = ST_OK;
                n_state  = S_FINAL;
            end
            S_FINAL: begin
                if (i_stat.out_free) begin
                    o_cmd.op = C_EMIT_FINAL;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ===== rtl/core/byte_budget_lru_directory.sv =====
// ----------------------------------------------------------------------------
// byte_budget_lru_directory
// Directory of a byte-budgeted cache with least-recently-written eviction.
// ----------------------------------------------------------------------------
// Requests enter on the s channel: tuser carries the action (get, put,
// clear), tdata the key and the byte size. Results leave on the m channel;
// tuser flags an eviction report and tlast marks the final result of a
// request. Registers byte_limit (index 0) and checks_on (index 1) are written
// through the cfg channel, which is always ready; the user must write them
// only while the block is idle; the block itself does not enforce this. One
// request is handled at a time. A get searches the table one entry per
// cycle, then writes its result. A put searches, checks budget and room,
// may evict (victim search, read, then a move that writes an eviction report)
// and updates or inserts; a clear, oversized put or zero limit skips search.
// A new request is taken in the cycle after the final result is written to
// the output register, even while that result still waits for the receiver.
// When the receiver stalls, the sequencer holds before writing its next
// result. Reset empties the directory, zeroes the byte count and write
// clock, sets byte_limit to 0 and checks_on to 1.
// ----------------------------------------------------------------------------
module byte_budget_lru_directory
    import bbld_pkg::*;
#(
    parameter int DEPTH    = DEPTH_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [63:0]  i_s_tdata,   // lookup_key[31:0], item_bytes[63:32]
    input  logic [1:0]   i_s_tuser,   // action[1:0]
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [111:0] o_m_tdata,   // evicted_key[31:0], status[33:32],
                                      // found_bytes[65:34], used_bytes[105:66]
    output logic [0:0]   o_m_tuser,   // is_eviction[0]
    output logic         o_m_tlast,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic         i_cfg_index,
    input  logic [31:0]  i_cfg_data
);

    t_ctrl_cmd   w_cmd;
    t_dp_stat    w_stat;
    logic        w_ev;
    logic [31:0] w_key;
    logic [1:0]  w_status;
    logic [31:0] w_bytes;
    logic [39:0] w_used;

    assign o_cfg_ready = 1'b1;

    bbld_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    bbld_dp #(
        .DEPTH    (DEPTH),
        .KEY_BITS (KEY_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_in_action  (i_s_tuser),
        .i_in_key     (i_s_tdata[31:0]),
        .i_in_bytes   (i_s_tdata[63:32]),
        .i_cfg_we     (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_stat       (w_stat),
        .i_out_ready  (i_m_tready),
        .o_out_valid  (o_m_tvalid),
        .o_out_ev     (w_ev),
        .o_out_key    (w_key),
        .o_out_status (w_status),
        .o_out_bytes  (w_bytes),
        .o_out_used   (w_used),
        .o_out_last   (o_m_tlast)
    );

    assign o_m_tdata = {6'b0, w_used, w_bytes, w_status, w_key};
    assign o_m_tuser = w_ev;

endmodule
